// File: rtl/b64lw_pkg.sv
// Shared types, constants and the base64 alphabet for the line-wrapping encoder.
`timescale 1ns / 1ps
package b64lw_pkg;

  localparam int LINE_CHARS_DEF = 64;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_t;

  // One complete group handed from the front to the back.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;  // bytes in the group, 1 to 3
    logic       last;   // group closes the message
  } grp_t;

  // Map a sextet to its character of the standard alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      b64_char = 8'h41 + w;
    end else if (v < 6'd52) begin
      b64_char = 8'h61 + (w - 8'd26);
    end else if (v < 6'd62) begin
      b64_char = 8'h30 + (w - 8'd52);
    end else if (v == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

// File: rtl/base64_encoder_line_wrap.sv
// A group-completing byte is queued, then its first character goes to the output register.
// The back end gives one character per cycle while a group is queued and out_ready is high;
// a group of three bytes gives four chars plus at most one wrap or closing newline.
// Bytes that only fill a group are taken in one cycle each while the queue has room.
// Reset (rst_n low, synchronous) empties the queue and clears group fill and line column.
`timescale 1ns / 1ps
module base64_encoder_line_wrap
  import b64lw_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic q_full;
  logic q_push;
  grp_t q_wdata;
  logic q_pop;
  logic q_head_valid;
  grp_t q_head;

  b64lw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  b64lw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  b64lw_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: rtl/b64lw_front.sv
// Front end: gathers input bytes into groups of three and pushes whole groups.
`timescale 1ns / 1ps
module b64lw_front
  import b64lw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_full,
  output logic q_push,
  output grp_t q_wdata
);

  logic [7:0] b0_r, b0_nxt;
  logic [7:0] b1_r, b1_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (in_data.in_last || fill_r == 2'd2);

  always_comb begin
    q_wdata.count = fill_r + 2'd1;
    q_wdata.last  = in_data.in_last;
    q_wdata.b0    = b0_r;
    q_wdata.b1    = b1_r;
    q_wdata.b2    = in_data.in_byte;
    unique case (fill_r)
      2'd0: begin
        q_wdata.b0 = in_data.in_byte;
        q_wdata.b1 = 8'h00;
        q_wdata.b2 = 8'h00;
      end
      2'd1: begin
        q_wdata.b1 = in_data.in_byte;
        q_wdata.b2 = 8'h00;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    b0_nxt   = b0_r;
    b1_nxt   = b1_r;
    fill_nxt = fill_r;
    if (accept) begin
      if (q_push) begin
        fill_nxt = 2'd0;
      end else begin
        // hold the byte until its group completes
        if (fill_r == 2'd0) begin
          b0_nxt = in_data.in_byte;
        end else begin
          b1_nxt = in_data.in_byte;
        end
        fill_nxt = fill_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// File: rtl/b64lw_fifo.sv
// Two-entry group queue between the front and the back.
`timescale 1ns / 1ps
module b64lw_fifo
  import b64lw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t wdata,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output grp_t head
);

  grp_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/b64lw_back.sv
// Back end: turns each group into characters, wraps lines and drives the output register.
`timescale 1ns / 1ps
module b64lw_back
  import b64lw_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  grp_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int COL_W = $clog2(LINE_CHARS);

  typedef enum logic [1:0] {
    S_CHAR,
    S_WRAP,
    S_CLOSE
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             advance;
  logic [5:0]       sextet;
  logic             pad;
  logic [7:0]       data_char;
  logic             line_full;

  assign advance   = head_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign line_full = ({1'b0, col_r} + (COL_W + 1)'(1)) == (COL_W + 1)'(LINE_CHARS);

  always_comb begin
    unique case (idx_r)
      2'd0: sextet = head.b0[7:2];
      2'd1: sextet = {head.b0[1:0], head.b1[7:4]};
      2'd2: sextet = {head.b1[3:0], head.b2[7:6]};
      default: sextet = head.b2[5:0];
    endcase
    pad = (idx_r == 2'd2 && head.count == 2'd1) ||
          (idx_r == 2'd3 && head.count != 2'd3);
    data_char = pad ? PAD_CHAR : b64_char(sextet);
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    wrapped_nxt   = wrapped_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = 1'b1;
      unique case (state_r)
        S_CHAR: begin
          out_data_nxt.out_char = data_char;
          out_data_nxt.out_last = 1'b0;
          idx_nxt               = idx_r + 2'd1;
          if (line_full) begin
            col_nxt     = '0;
            wrapped_nxt = 1'b1;
            state_nxt   = S_WRAP;
          end else begin
            col_nxt = col_r + COL_W'(1);
            if (idx_r == 2'd3) begin
              if (head.last && !wrapped_r) begin
                state_nxt = S_CLOSE;
              end else begin
                // closing newline would be a sixth character: drop it
                out_data_nxt.out_last = head.last;
                pop         = 1'b1;
                wrapped_nxt = 1'b0;
                if (head.last) begin
                  col_nxt = '0;
                end
              end
            end
          end
        end
        S_WRAP: begin
          out_data_nxt.out_char = NEWLINE_CHAR;
          out_data_nxt.out_last = 1'b0;
          if (idx_r == 2'd0) begin
            // wrap followed the fourth character: group is done
            out_data_nxt.out_last = head.last;
            pop         = 1'b1;
            wrapped_nxt = 1'b0;
          end
          state_nxt = S_CHAR;
        end
        default: begin
          out_data_nxt.out_char = NEWLINE_CHAR;
          out_data_nxt.out_last = 1'b1;
          col_nxt     = '0;
          pop         = 1'b1;
          wrapped_nxt = 1'b0;
          state_nxt   = S_CHAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_CHAR;
      idx_r       <= 2'd0;
      col_r       <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
